[rtl/core/acsc_pkg.sv]
// ----------------------------------------------------------------------------
// acsc_pkg: shared types and constants of the alarm clock slot controller
// Holds the input and result word layouts and the calendar field limits.
// ----------------------------------------------------------------------------
package acsc_pkg;

    localparam int NUM_SLOTS = 5;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // button bit positions
    localparam int BTN_MODE  = 0;
    localparam int BTN_UP    = 1;
    localparam int BTN_DOWN  = 2;
    localparam int BTN_SET   = 3;
    localparam int BTN_ALARM = 4;
    localparam int BTN_BACK  = 5;

    localparam logic [5:0] MINUTE_TOP = 6'd59;
    localparam logic [4:0] HOUR_TOP   = 5'd23;
    localparam logic [4:0] DAY_TOP    = 5'd31;
    localparam logic [2:0] WDAY_TOP   = 3'd6;
    localparam logic [3:0] MONTH_TOP  = 4'd12;
    localparam logic [6:0] YEAR_TOP   = 7'd99;

    // view codes
    localparam logic [1:0] VIEW_CLOCK = 2'd0;
    localparam logic [1:0] VIEW_TIME  = 2'd1;
    localparam logic [1:0] VIEW_SLOT  = 2'd2;
    localparam logic [1:0] VIEW_ALARM = 2'd3;

    typedef struct packed {
        logic [5:0] buttons;
        logic [5:0] now_second;
        logic [5:0] now_minute;
        logic [4:0] now_hour;
        logic [4:0] now_day;
        logic [2:0] now_weekday;
        logic [3:0] now_month;
        logic [6:0] now_year;
    } t_in_word;

    typedef struct packed {
        logic       buzzer_pulse;
        logic       ringing;
        logic       time_write;
        logic [1:0] view_mode;
        logic [2:0] field_select;
        logic [2:0] shown_slot;
        logic [5:0] edit_minute;
        logic [4:0] edit_hour;
        logic [4:0] edit_day;
        logic [2:0] edit_weekday;
        logic [3:0] edit_month;
        logic [6:0] edit_year;
    } t_out_word;

    typedef struct packed {
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
    } t_aval;

    // scan request to the compare unit
    typedef struct packed {
        logic       valid;
        t_aval      slot;
        logic       armed;
        logic       enabled;
        t_aval      now;
    } t_cmp_req;

endpackage

[rtl/core/acsc_slot_cmp.sv]
// ----------------------------------------------------------------------------
// acsc_slot_cmp: shared slot compare unit
// Compares one stored slot against the current time per cycle.
// ----------------------------------------------------------------------------
module acsc_slot_cmp (
    input  acsc_pkg::t_cmp_req i_req,
    output logic               o_hit
);
    import acsc_pkg::*;

    // match only armed, enabled slots on all four fields
    assign o_hit = i_req.valid && i_req.armed && i_req.enabled &&
                   (i_req.slot == i_req.now);

endmodule

[rtl/core/alarm_clock_slot_controller_core.sv]
// ----------------------------------------------------------------------------
// alarm_clock_slot_controller_core: alarm clock slot controller
// One poll word in, one status word out, slots scanned by a shared compare.
// ----------------------------------------------------------------------------
// An accepted poll word first passes the prep step, which applies the
// re-enable and edit-entry rules, then the scan, which feeds one slot per
// cycle through the single compare unit, then the finish step, which
// completes edits and registers the result. A poll that lands in alarm edit
// skips the scan. The input is ready again as soon as the sequencer is back
// in idle, so no new poll word is taken before the last one is through.
// A result still waiting in the output register holds the finish step of
// the next poll.
module alarm_clock_slot_controller_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  acsc_pkg::t_in_word   i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output acsc_pkg::t_out_word  o_data
);
    import acsc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PREP = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    t_state r_state;
    t_in_word r_in;
    logic [SLOT_W-1:0] r_idx;
    logic r_time_editing, r_alarm_editing, r_slot_chosen, r_alarm_active;
    logic [2:0] r_time_field;
    logic [1:0] r_alarm_field;
    logic [SLOT_W-1:0] r_cursor, r_active_slot;
    logic [5:0] r_wt_min;
    logic [4:0] r_wt_hour, r_wt_day;
    logic [2:0] r_wt_wday;
    logic [3:0] r_wt_mon;
    logic [6:0] r_wt_year;
    t_aval r_wa;
    t_aval r_slot [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_armed, r_enabled;
    logic r_pulse;
    logic r_out_valid;
    t_out_word r_out;

    t_cmp_req w_req;
    logic w_hit;
    logic w_fin;

    logic k_mode, k_up, k_down, k_set, k_alarm, k_back;
    assign k_mode  = r_in.buttons[BTN_MODE];
    assign k_up    = r_in.buttons[BTN_UP];
    assign k_down  = r_in.buttons[BTN_DOWN];
    assign k_set   = r_in.buttons[BTN_SET];
    assign k_alarm = r_in.buttons[BTN_ALARM];
    assign k_back  = r_in.buttons[BTN_BACK];

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // finish only when the output register is free or drains this cycle
    assign w_fin = !r_out_valid || i_ready;

    // feed one slot a cycle to the compare unit
    always_comb begin
        w_req.valid   = (r_state == ST_SCAN);
        w_req.slot    = r_slot[r_idx];
        w_req.armed   = r_armed[r_idx];
        w_req.enabled = r_enabled[r_idx];
        w_req.now     = '{minute: r_in.now_minute, hour: r_in.now_hour,
                          day: r_in.now_day, month: r_in.now_month};
    end

    acsc_slot_cmp u_cmp (
        .i_req (w_req),
        .o_hit (w_hit)
    );

    // step helpers
    function automatic logic [6:0] f_inc(input logic [6:0] v, input logic [6:0] top,
                                         input logic [6:0] bot);
        f_inc = (v >= top) ? bot : v + 7'd1;
    endfunction
    function automatic logic [6:0] f_dec(input logic [6:0] v, input logic [6:0] top,
                                         input logic [6:0] bot);
        f_dec = (v <= bot) ? top : v - 7'd1;
    endfunction
    function automatic logic [6:0] f_step(input logic [6:0] v, input logic [6:0] top,
                                          input logic [6:0] bot, input logic up,
                                          input logic dn);
        logic [6:0] t;
        t = up ? f_inc(v, top, bot) : v;
        f_step = dn ? f_dec(t, top, bot) : t;
    endfunction

    // sequencer and state update
    always_ff @(posedge i_clk) begin
        logic       te, ae, sc, aa;
        logic [2:0] tf;
        logic [1:0] af;
        logic [6:0] tmp;
        logic [SLOT_W-1:0] ix;
        t_out_word ow;
        t_aval     shown;
        t_aval     wa;
        logic [5:0] wmin;
        logic [4:0] whour, wday;
        logic [2:0] wwday;
        logic [3:0] wmon;
        logic [6:0] wyear;
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_time_editing <= 1'b0;
            r_alarm_editing <= 1'b0;
            r_slot_chosen <= 1'b0;
            r_alarm_active <= 1'b0;
            r_time_field <= '0;
            r_alarm_field <= '0;
            r_cursor <= '0;
            r_active_slot <= '0;
            r_wt_min <= '0; r_wt_hour <= '0; r_wt_day <= '0;
            r_wt_wday <= '0; r_wt_mon <= '0; r_wt_year <= '0;
            r_wa <= '0;
            r_armed <= '0;
            r_enabled <= '1;
            r_idx <= '0;
            r_pulse <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) r_slot[i] <= '0;
        end else begin
            // raise the result at finish, drop it once taken
            if (r_state == ST_DONE && w_fin) r_out_valid <= 1'b1;
            else if (o_valid && i_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_in <= i_data;
                        r_state <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    // re-enable at midnight, enter alarm edit
                    if (r_in.now_second <= 6'd3 && r_in.now_minute == '0 &&
                        r_in.now_hour == '0)
                        r_enabled <= '1;
                    r_pulse <= 1'b0;
                    r_idx <= '0;
                    if ((k_alarm && !r_alarm_active) || r_alarm_editing) begin
                        r_alarm_editing <= 1'b1;
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // record the last matching slot
                    if (w_hit) begin
                        r_active_slot <= r_idx;
                        r_alarm_active <= 1'b1;
                        r_pulse <= 1'b1;
                    end
                    if (r_idx == SLOT_W'(NUM_SLOTS - 1)) r_state <= ST_DONE;
                    else r_idx <= r_idx + 1'b1;
                end
                ST_DONE: begin
                    if (w_fin) begin
                        te = r_time_editing; ae = r_alarm_editing; sc = r_slot_chosen;
                        aa = r_alarm_active; tf = r_time_field; af = r_alarm_field;
                        ix = r_cursor; wa = r_wa;
                        wmin = r_wt_min; whour = r_wt_hour; wday = r_wt_day;
                        wwday = r_wt_wday; wmon = r_wt_mon; wyear = r_wt_year;
                        ow = '0;
                        if (ae) begin
                            if (!sc) begin
                                if (k_up) ix = (ix >= SLOT_W'(NUM_SLOTS - 1)) ? '0 : ix + 1'b1;
                                if (k_set) begin
                                    sc = 1'b1;
                                    wa = r_slot[ix];
                                end
                            end else begin
                                if (k_mode) af = af + 2'd1;
                                unique case (af)
                                    2'd0: begin
                                        tmp = f_step({1'b0, wa.minute}, 7'(MINUTE_TOP), 7'd0,
                                                     k_up, k_down);
                                        wa.minute = tmp[5:0];
                                    end
                                    2'd1: begin
                                        tmp = f_step({2'b0, wa.hour}, 7'(HOUR_TOP), 7'd0,
                                                     k_up, k_down);
                                        wa.hour = tmp[4:0];
                                    end
                                    2'd2: begin
                                        tmp = f_step({2'b0, wa.day}, 7'(DAY_TOP), 7'd1,
                                                     k_up, k_down);
                                        wa.day = tmp[4:0];
                                    end
                                    default: begin
                                        tmp = f_step({3'b0, wa.month}, 7'(MONTH_TOP), 7'd1,
                                                     k_up, k_down);
                                        wa.month = tmp[3:0];
                                    end
                                endcase
                                if (k_set) begin
                                    r_slot[ix] <= wa;
                                    r_armed[ix] <= 1'b1;
                                    r_enabled[ix] <= 1'b1;
                                    ae = 1'b0;
                                    sc = 1'b0;
                                end
                            end
                        end else begin
                            // stop ringing, disarm the matched slot
                            if (k_alarm && aa) begin
                                r_enabled[r_active_slot] <= 1'b0;
                                r_armed[r_active_slot] <= 1'b0;
                                aa = 1'b0;
                            end
                            if (k_mode && !te) begin
                                te = 1'b1;
                                wmin = r_in.now_minute; whour = r_in.now_hour;
                                wday = r_in.now_day; wwday = r_in.now_weekday;
                                wmon = r_in.now_month; wyear = r_in.now_year;
                            end
                            if (te) begin
                                if (k_mode) tf = (tf >= 3'd4) ? 3'd0 : tf + 3'd1;
                                // step the selected time field
                                unique case (tf)
                                    3'd0: begin
                                        tmp = f_step({1'b0, wmin}, 7'(MINUTE_TOP), 7'd0,
                                                     k_up, k_down);
                                        wmin = tmp[5:0];
                                    end
                                    3'd1: begin
                                        tmp = f_step({2'b0, whour}, 7'(HOUR_TOP), 7'd0,
                                                     k_up, k_down);
                                        whour = tmp[4:0];
                                    end
                                    3'd2: begin
                                        tmp = f_step({2'b0, wday}, 7'(DAY_TOP), 7'd1,
                                                     k_up, k_down);
                                        wday = tmp[4:0];
                                        tmp = f_step({4'b0, wwday}, 7'(WDAY_TOP), 7'd0,
                                                     k_up, k_down);
                                        wwday = tmp[2:0];
                                    end
                                    3'd3: begin
                                        tmp = f_step({3'b0, wmon}, 7'(MONTH_TOP), 7'd1,
                                                     k_up, k_down);
                                        wmon = tmp[3:0];
                                    end
                                    default: begin
                                        tmp = f_step(wyear, YEAR_TOP, 7'd0, k_up, k_down);
                                        wyear = tmp;
                                    end
                                endcase
                                if (k_set) begin
                                    ow.time_write = 1'b1;
                                    te = 1'b0;
                                end
                            end
                        end
                        if (k_back) begin
                            te = 1'b0; ae = 1'b0; sc = 1'b0;
                        end
                        r_time_editing <= te; r_alarm_editing <= ae; r_slot_chosen <= sc;
                        r_alarm_active <= aa; r_time_field <= tf; r_alarm_field <= af;
                        r_cursor <= ix; r_wa <= wa;
                        r_wt_min <= wmin; r_wt_hour <= whour; r_wt_day <= wday;
                        r_wt_wday <= wwday; r_wt_mon <= wmon; r_wt_year <= wyear;
                        // build the status word from the new view
                        ow.buzzer_pulse = r_pulse;
                        ow.ringing = aa;
                        ow.shown_slot = 3'(ix);
                        if (ae) begin
                            shown = sc ? wa : r_slot[ix];
                            ow.view_mode = sc ? VIEW_ALARM : VIEW_SLOT;
                            ow.field_select = sc ? {1'b0, af} : 3'd0;
                            ow.edit_minute = shown.minute; ow.edit_hour = shown.hour;
                            ow.edit_day = shown.day; ow.edit_month = shown.month;
                        end else begin
                            ow.view_mode = te ? VIEW_TIME : VIEW_CLOCK;
                            ow.field_select = tf;
                            ow.edit_minute = wmin; ow.edit_hour = whour;
                            ow.edit_day = wday; ow.edit_weekday = wwday;
                            ow.edit_month = wmon; ow.edit_year = wyear;
                        end
                        r_out <= ow;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // a result is raised once the finish step runs
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |=> r_out_valid)
        else $error("result not raised after poll");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_ready)
        else $error("ready while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state not one-hot");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))
        else $error("result word changed while waiting");
endmodule

[verif/alarm_clock_slot_controller_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alarm_clock_slot_controller_core_test: poll-by-poll check of the controller
// Drives poll words with random gaps and back-pressure, predicts each status
// word from an internal copy of the edit modes and alarm slots, and compares.
// ----------------------------------------------------------------------------
module alarm_clock_slot_controller_core_test;
    import acsc_pkg::*;

    localparam int IDLE_MAX  = 17;
    localparam int WDOG_MAX  = 2000;
    localparam int DRAIN_CYC = 40;
    localparam int N_ITEMS   = 1000;

    localparam logic [5:0] K_MODE  = 6'b000001;
    localparam logic [5:0] K_UP    = 6'b000010;
    localparam logic [5:0] K_DOWN  = 6'b000100;
    localparam logic [5:0] K_SET   = 6'b001000;
    localparam logic [5:0] K_ALARM = 6'b010000;
    localparam logic [5:0] K_BACK  = 6'b100000;

    typedef struct {
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day;
        logic [2:0] weekday;
        logic [3:0] month;
        logic [6:0] year;
    } t_stamp;

    // ------------------------------------------------------------------------
    // Status word predictor and store of pending status words
    // ------------------------------------------------------------------------
    class status_board;
        bit         time_editing, alarm_editing, slot_chosen, alarm_active;
        int         time_field, alarm_field, cursor_slot, active_slot;
        t_stamp     work_time;
        t_aval      work_alarm;
        t_aval      slot_val [NUM_SLOTS];
        bit         slot_armed [NUM_SLOTS];
        bit         slot_en [NUM_SLOTS];
        t_out_word  pending [$];
        int         errors;

        function void clear();
            time_editing = 0; alarm_editing = 0; slot_chosen = 0; alarm_active = 0;
            time_field = 0; alarm_field = 0; cursor_slot = 0; active_slot = 0;
            work_time = '{default: 0};
            work_alarm = '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                slot_val[i] = '0; slot_armed[i] = 0; slot_en[i] = 1;
            end
            pending.delete();
            errors = 0;
        endfunction

        function int up(int v, int top, int bot);
            return (v >= top) ? bot : v + 1;
        endfunction

        function int dn(int v, int top, int bot);
            return (v <= bot) ? top : v - 1;
        endfunction

        function int stp(int dir, int v, int top, int bot);
            return (dir > 0) ? up(v, top, bot) : dn(v, top, bot);
        endfunction

        function void step_alarm(int dir);
            case (alarm_field)
                0: work_alarm.minute = 6'(stp(dir, work_alarm.minute, 59, 0));
                1: work_alarm.hour = 5'(stp(dir, work_alarm.hour, 23, 0));
                2: work_alarm.day = 5'(stp(dir, work_alarm.day, 31, 1));
                default: work_alarm.month = 4'(stp(dir, work_alarm.month, 12, 1));
            endcase
        endfunction

        function void step_time(int dir);
            case (time_field)
                0: work_time.minute = 6'(stp(dir, work_time.minute, 59, 0));
                1: work_time.hour = 5'(stp(dir, work_time.hour, 23, 0));
                2: begin
                    work_time.day = 5'(stp(dir, work_time.day, 31, 1));
                    work_time.weekday = 3'(stp(dir, work_time.weekday, 6, 0));
                end
                3: work_time.month = 4'(stp(dir, work_time.month, 12, 1));
                default: work_time.year = 7'(stp(dir, work_time.year, 99, 0));
            endcase
        endfunction

        // note an accepted poll word and queue its status word
        function void note_poll(t_in_word w);
            bit        k_mode, k_up, k_down, k_set, k_alarm, k_back, pulse, twrite;
            t_out_word r;
            t_aval     a;
            k_mode = w.buttons[BTN_MODE];   k_up = w.buttons[BTN_UP];
            k_down = w.buttons[BTN_DOWN];   k_set = w.buttons[BTN_SET];
            k_alarm = w.buttons[BTN_ALARM]; k_back = w.buttons[BTN_BACK];
            pulse = 0; twrite = 0;

            // re-enable every slot just after midnight
            if (w.now_second <= 3 && w.now_minute == 0 && w.now_hour == 0)
                for (int i = 0; i < NUM_SLOTS; i++) slot_en[i] = 1;
            if (k_alarm && !alarm_active && !alarm_editing) alarm_editing = 1;

            if (alarm_editing) begin
                if (!slot_chosen) begin
                    if (k_up) cursor_slot = up(cursor_slot, NUM_SLOTS - 1, 0);
                    if (k_set) begin
                        slot_chosen = 1;
                        work_alarm = slot_val[cursor_slot];
                    end
                end else begin
                    if (k_mode) alarm_field = up(alarm_field, 3, 0);
                    if (k_up) step_alarm(1);
                    if (k_down) step_alarm(-1);
                    if (k_set) begin
                        slot_val[cursor_slot] = work_alarm;
                        slot_armed[cursor_slot] = 1;
                        slot_en[cursor_slot] = 1;
                        alarm_editing = 0;
                        slot_chosen = 0;
                    end
                end
            end else begin
                // scan slots, last match wins
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (slot_val[i].minute == w.now_minute &&
                        slot_val[i].hour == w.now_hour &&
                        slot_val[i].day == w.now_day && slot_val[i].month == w.now_month &&
                        slot_armed[i] && slot_en[i]) begin
                        active_slot = i; alarm_active = 1; pulse = 1;
                    end
                if (k_alarm && alarm_active) begin
                    slot_en[active_slot] = 0;
                    slot_armed[active_slot] = 0;
                    alarm_active = 0;
                end
                if (k_mode && !time_editing) begin
                    time_editing = 1;
                    work_time = '{w.now_minute, w.now_hour, w.now_day, w.now_weekday,
                                  w.now_month, w.now_year};
                end
                if (time_editing) begin
                    if (k_mode) time_field = up(time_field, 4, 0);
                    if (k_up) step_time(1);
                    if (k_down) step_time(-1);
                    if (k_set) begin
                        twrite = 1; time_editing = 0;
                    end
                end
            end

            if (k_back) begin
                time_editing = 0; alarm_editing = 0; slot_chosen = 0;
            end

            r = '0;
            r.buzzer_pulse = pulse;
            r.ringing = alarm_active;
            r.time_write = twrite;
            r.shown_slot = cursor_slot[2:0];
            if (alarm_editing) begin
                a = slot_chosen ? work_alarm : slot_val[cursor_slot];
                r.view_mode = slot_chosen ? VIEW_ALARM : VIEW_SLOT;
                r.field_select = slot_chosen ? alarm_field[2:0] : 3'd0;
                r.edit_minute = a.minute; r.edit_hour = a.hour;
                r.edit_day = a.day; r.edit_month = a.month;
            end else begin
                r.view_mode = time_editing ? VIEW_TIME : VIEW_CLOCK;
                r.field_select = time_field[2:0];
                r.edit_minute = work_time.minute; r.edit_hour = work_time.hour;
                r.edit_day = work_time.day; r.edit_weekday = work_time.weekday;
                r.edit_month = work_time.month; r.edit_year = work_time.year;
            end
            pending.push_back(r);
        endfunction

        function void flag(string nm, int e, int a);
            $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, nm, e, a);
            errors++;
        endfunction

        // compare one status word with the oldest prediction
        function void check_status(t_out_word a);
            t_out_word e;
            if (pending.size() == 0) begin
                $display("%0t ns: status word with none expected, actual %h", $time, a);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.buzzer_pulse !== e.buzzer_pulse)
                flag("buzzer_pulse", e.buzzer_pulse, a.buzzer_pulse);
            if (a.ringing !== e.ringing) flag("ringing", e.ringing, a.ringing);
            if (a.time_write !== e.time_write)
                flag("time_write", e.time_write, a.time_write);
            if (a.view_mode !== e.view_mode) flag("view_mode", e.view_mode, a.view_mode);
            if (a.field_select !== e.field_select)
                flag("field_select", e.field_select, a.field_select);
            if (a.shown_slot !== e.shown_slot)
                flag("shown_slot", e.shown_slot, a.shown_slot);
            if (a.edit_minute !== e.edit_minute)
                flag("edit_minute", e.edit_minute, a.edit_minute);
            if (a.edit_hour !== e.edit_hour) flag("edit_hour", e.edit_hour, a.edit_hour);
            if (a.edit_day !== e.edit_day) flag("edit_day", e.edit_day, a.edit_day);
            if (a.edit_weekday !== e.edit_weekday)
                flag("edit_weekday", e.edit_weekday, a.edit_weekday);
            if (a.edit_month !== e.edit_month)
                flag("edit_month", e.edit_month, a.edit_month);
            if (a.edit_year !== e.edit_year) flag("edit_year", e.edit_year, a.edit_year);
        endfunction
    endclass

    logic      i_clk = 0;
    logic      i_rst_n = 0;
    logic      i_valid = 0;
    logic      o_ready;
    t_in_word  i_data = '0;
    logic      o_valid;
    logic      i_ready = 0;
    t_out_word o_data;

    status_board board = new();
    int          stall_cnt = 0;
    int          sent = 0;
    bit          sender_done = 0;
    // last time seen, reused so slot values come back round and ring
    t_aval       recent [$];

    alarm_clock_slot_controller_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // ------------------------------------------------------------------------
    // Sample both channels, score results, watch for a hang
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) board.note_poll(i_data);
            if (o_valid && i_ready) board.check_status(o_data);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                stall_cnt <= 0;
            end else begin
                stall_cnt <= stall_cnt + 1;
                if (stall_cnt >= WDOG_MAX) begin
                    $display("alarm_clock_slot_controller_core_test: done, errors");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side: random back-pressure per word
    // ------------------------------------------------------------------------
    initial begin : drain_side
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, IDLE_MAX);
            repeat (gap) @(negedge i_clk);
            @(negedge i_clk);
            i_ready <= 1;
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
            i_ready <= 0;
        end
    end

    // send one poll word, with a random lead gap unless quick
    task automatic send_poll(int btn, t_aval tv, int sec, int quick);
        int gap;
        t_in_word w;
        gap = (quick != 0) ? 0 : $urandom_range(0, IDLE_MAX);
        repeat (gap) @(negedge i_clk);
        @(negedge i_clk);
        w.buttons = 6'(btn); w.now_second = 6'(sec);
        w.now_minute = tv.minute; w.now_hour = tv.hour; w.now_day = tv.day;
        w.now_month = tv.month;
        w.now_weekday = 3'($urandom_range(0, 7));
        w.now_year = 7'($urandom_range(0, 127));
        i_data <= w;
        i_valid <= 1;
        do @(posedge i_clk); while (!o_ready);
        sent++;
        @(negedge i_clk);
        i_valid <= 0;
    endtask

    function automatic t_aval any_time();
        t_aval t;
        if (recent.size() > 0 && $urandom_range(0, 2) == 0)
            return recent[$urandom_range(0, recent.size() - 1)];
        t.minute = 6'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                  : $urandom_range(0, 59));
        t.hour = 5'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                : $urandom_range(0, 23));
        t.day = 5'($urandom_range(0, 31));
        t.month = 4'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                 : $urandom_range(1, 12));
        return t;
    endfunction

    function automatic logic [5:0] edit_keys();
        case ($urandom_range(0, 5))
            0: return K_UP;
            1: return K_DOWN;
            2: return K_MODE;
            3: return K_UP | K_DOWN;
            4: return K_MODE | K_UP;
            default: return 6'($urandom_range(0, 63)) & ~(K_SET | K_BACK);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : feed_side
        t_aval t0, tmax, tv;
        int    sel;
        board.clear();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: extremes and every button
        t0 = '0;
        tmax = '1;
        send_poll(0, t0, 0, 0);
        send_poll(63, tmax, 63, 0);
        send_poll(K_MODE, tmax, 5, 0);              // time edit from out-of-range time
        for (int f = 0; f < 5; f++) begin
            send_poll(K_UP, t0, 10, 1);
            send_poll(K_DOWN | K_UP, t0, 10, 1);
            send_poll(K_DOWN, t0, 10, 0);
            send_poll(K_MODE, t0, 10, 1);
        end
        send_poll(K_SET, t0, 10, 0);                // write strobe
        // pick slot 0 after the cursor wraps, then arm it with a stepped minute
        tv = '{minute: 6'd0, hour: 5'd0, day: 5'd1, month: 4'd1};
        send_poll(K_ALARM, tv, 30, 0);
        repeat (4) send_poll(K_UP, tv, 30, 1);
        send_poll(K_UP, tv, 30, 0);                 // cursor wraps
        send_poll(K_SET, tv, 30, 0);
        send_poll(K_DOWN, tv, 30, 0);               // minute below 0 to 59
        send_poll(K_SET, tv, 30, 0);
        send_poll(K_BACK | K_MODE, tv, 30, 0);
        send_poll(K_ALARM, tv, 2, 0);               // midnight re-enable

        // pause until every status word is back
        wait (board.pending.size() == 0);

        // random: mostly well-formed edit sessions, some noise
        while (sent < N_ITEMS) begin
            sel = $urandom_range(0, 9);
            tv = any_time();
            if (sel < 4) begin
                // alarm slot session
                send_poll(K_ALARM, tv, $urandom_range(0, 63), 0);
                repeat ($urandom_range(0, 5)) send_poll(K_UP, tv, 20, $urandom_range(0, 1));
                send_poll(K_SET, tv, 20, 0);
                repeat ($urandom_range(0, 6))
                    send_poll(edit_keys(), tv, 20, $urandom_range(0, 1));
                send_poll(($urandom_range(0, 7) == 0) ? K_BACK : K_SET, tv, 20, 0);
                recent.push_back(tv);
                if (recent.size() > 8) void'(recent.pop_front());
            end else if (sel < 7) begin
                // time edit session
                send_poll(K_MODE, tv, $urandom_range(0, 63), 0);
                repeat ($urandom_range(0, 6))
                    send_poll(edit_keys(), tv, 20, $urandom_range(0, 1));
                send_poll(($urandom_range(0, 7) == 0) ? K_BACK : K_SET, tv, 20, 0);
            end else if (sel < 9) begin
                // poll at a remembered time so armed slots ring, maybe stop them
                send_poll($urandom_range(0, 1) ? 0 : K_ALARM, tv,
                          $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 63),
                          0);
                send_poll(K_ALARM, tv, 40, $urandom_range(0, 1));
            end else begin
                send_poll($urandom_range(0, 63), tv, $urandom_range(0, 63),
                          $urandom_range(0, 1));
            end
        end
        sender_done = 1;
    end

    // ------------------------------------------------------------------------
    // End of run
    // ------------------------------------------------------------------------
    initial begin : finish_side
        wait (sender_done);
        wait (board.pending.size() == 0);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("alarm_clock_slot_controller_core_test: done, clean");
        end else begin
            $display("alarm_clock_slot_controller_core_test: done, errors");
        end
        $finish;
    end

endmodule
